/* rtl/core/fbcm_pkg.sv */
// ----------------------------------------------------------------------------
// fbcm_pkg
// Shared types, codes and the round function of the Feistel cipher engine.
// ----------------------------------------------------------------------------
package fbcm_pkg;

    localparam int BLK_W   = 64;
    localparam int WORD_W  = 32;
    localparam int KIND_W  = 3;
    localparam int ROW_W   = 3;
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int ROWS    = 8;
    localparam int ROT_L   = 11;
    localparam int ROT_R   = 21;
    localparam int RND_W   = 5;

    localparam logic [WORD_W-1:0] CTR_ADD_LO  = 32'h0101_0101;
    localparam logic [WORD_W-1:0] CTR_ADD_HI  = 32'h0101_0104;
    localparam logic [WORD_W-1:0] CTR_ADD_HI1 = 32'h0101_0105;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY45 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY67 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd4;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_SBOX = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET_IV    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET_MAC   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INIT_CTR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PROCESS   = 3'd4;

    // modes
    localparam logic [MODE_W-1:0] MODE_ECB_ENC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ECB_DEC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CTR     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CFB_ENC = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CFB_DEC = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MAC     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_ENC16   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_DEC16   = 3'd7;

    typedef logic [ROWS-1:0][BLK_W-1:0] sbox_t;

    typedef enum logic [1:0] {
        CIPH_ENC32 = 2'd0,
        CIPH_DEC32 = 2'd1,
        CIPH_ENC16 = 2'd2,
        CIPH_DEC16 = 2'd3
    } ciph_t;

    // what happens with the cipher output when the item finishes
    typedef enum logic [2:0] {
        FIN_IMM     = 3'd0,
        FIN_PLAIN   = 3'd1,
        FIN_XOR     = 3'd2,
        FIN_CFB_ENC = 3'd3,
        FIN_CFB_DEC = 3'd4,
        FIN_MAC     = 3'd5,
        FIN_CHAIN   = 3'd6
    } fin_t;

    function automatic logic [2:0] key_sel(input ciph_t ciph, input logic [RND_W-1:0] rnd);
        logic [2:0] up;
        up = rnd[2:0];
        case (ciph)
            CIPH_ENC32: key_sel = (rnd[4:3] == 2'd3) ? ~up : up;
            CIPH_DEC32: key_sel = (rnd[4:3] == 2'd0) ? up : ~up;
            CIPH_ENC16: key_sel = up;
            default:    key_sel = ~up;
        endcase
    endfunction

    // add key, substitute each nibble through its own row, rotate left
    function automatic logic [WORD_W-1:0] round_f(
        input logic [WORD_W-1:0] half,
        input logic [WORD_W-1:0] key,
        input sbox_t             sbox
    );
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] s;
        t = half + key;
        s = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            s[4*i +: 4] = sbox[i][4*t[4*i +: 4] +: 4];
        end
        round_f = {s[WORD_W-1-ROT_L:0], s[WORD_W-1:ROT_R]};
    endfunction

endpackage

/* rtl/core/fbcm_if.sv */
// ----------------------------------------------------------------------------
// fbcm_if
// Valid/ready channels of the Feistel cipher engine: items, results, config.
// ----------------------------------------------------------------------------
interface fbcm_item_if;
    logic                            valid;
    logic                            ready;
    logic [fbcm_pkg::KIND_W-1:0]     kind;
    logic [fbcm_pkg::ROW_W-1:0]      row_index;
    logic [fbcm_pkg::BLK_W-1:0]      block_in;
    logic                            last_block;

    modport source (output valid, kind, row_index, block_in, last_block, input ready);
    modport sink   (input valid, kind, row_index, block_in, last_block, output ready);
endinterface

interface fbcm_result_if;
    logic                            valid;
    logic                            ready;
    logic [fbcm_pkg::BLK_W-1:0]      block_out;
    logic                            last;

    modport source (output valid, block_out, last, input ready);
    modport sink   (input valid, block_out, last, output ready);
endinterface

interface fbcm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fbcm_pkg::CFG_IDX_W-1:0]  index;
    logic [fbcm_pkg::BLK_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/feistel_block_cipher_modes_top.sv */
// ----------------------------------------------------------------------------
// feistel_block_cipher_modes_top
// One round per cycle on a single unit, for 32-round and 16-round work alike;
// loads and sets pass to the result register without any rounds.
// The item port waits while an item is in work; one item is taken at a time.
// Reset: keys, mode, S-box rows, chain and mac values clear to zero at once.
// ----------------------------------------------------------------------------
module feistel_block_cipher_modes_top (
    input  logic                 clk,
    input  logic                 rst_n,
    fbcm_cfg_if.sink             cfg,
    fbcm_item_if.sink            item,
    fbcm_result_if.source        result
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t                                 state_reg, state_next;
    logic [3:0][fbcm_pkg::BLK_W-1:0]        key_reg;
    logic [fbcm_pkg::MODE_W-1:0]            mode_reg;
    fbcm_pkg::sbox_t                        sbox_reg;
    logic [fbcm_pkg::BLK_W-1:0]             chain_reg, chain_next;
    logic [fbcm_pkg::BLK_W-1:0]             mac_reg, mac_next;
    logic [fbcm_pkg::RND_W-1:0]             rnd_reg, rnd_next;
    fbcm_pkg::ciph_t                        ciph_reg, ciph_next;
    fbcm_pkg::fin_t                         fin_reg, fin_next;
    logic [fbcm_pkg::WORD_W-1:0]            n1_reg, n1_next;
    logic [fbcm_pkg::WORD_W-1:0]            n2_reg, n2_next;
    logic [fbcm_pkg::BLK_W-1:0]             blk_reg, blk_next;
    logic                                   last_reg;
    logic                                   out_valid_reg;
    logic [fbcm_pkg::BLK_W-1:0]             out_blk_reg;
    logic                                   out_last_reg;

    logic                                   item_xfer;
    logic                                   cfg_xfer;
    logic                                   slot_free;
    logic                                   fin_go;
    logic                                   last_rnd;
    logic                                   sbox_we;
    logic [2:0]                             ksel;
    logic [fbcm_pkg::WORD_W-1:0]            kword;
    logic [fbcm_pkg::WORD_W-1:0]            f_out;
    logic [fbcm_pkg::BLK_W-1:0]             src;
    logic [fbcm_pkg::BLK_W-1:0]             ciph_out;
    logic [fbcm_pkg::BLK_W-1:0]             res;
    logic [fbcm_pkg::BLK_W-1:0]             ctr_val;
    logic [fbcm_pkg::WORD_W:0]              ctr_hi_sum;

    assign cfg.ready    = 1'b1;
    assign cfg_xfer     = cfg.valid & cfg.ready;
    assign item.ready   = (state_reg == ST_IDLE);
    assign item_xfer    = item.valid & item.ready;
    assign slot_free    = ~out_valid_reg | result.ready;
    assign fin_go       = (state_reg == ST_FIN) & slot_free;
    assign sbox_we      = item_xfer & (item.kind == fbcm_pkg::KIND_LOAD_SBOX);

    assign result.valid     = out_valid_reg;
    assign result.block_out = out_blk_reg;
    assign result.last      = out_last_reg;

    // shared round unit
    assign ksel  = fbcm_pkg::key_sel(ciph_reg, rnd_reg);
    assign kword = ksel[0] ? key_reg[ksel[2:1]][63:32] : key_reg[ksel[2:1]][31:0];
    assign f_out = fbcm_pkg::round_f(n1_reg, kword, sbox_reg);
    assign last_rnd = (rnd_reg == {(ciph_reg == fbcm_pkg::CIPH_ENC32 ||
                                    ciph_reg == fbcm_pkg::CIPH_DEC32), 4'hF});

    // counter step: low word mod 2^32, high word mod 2^32-1
    assign ctr_hi_sum = {1'b0, chain_reg[63:32]} + {1'b0, fbcm_pkg::CTR_ADD_HI};
    assign ctr_val[31:0]  = chain_reg[31:0] + fbcm_pkg::CTR_ADD_LO;
    assign ctr_val[63:32] = ctr_hi_sum[fbcm_pkg::WORD_W] ?
                            chain_reg[63:32] + fbcm_pkg::CTR_ADD_HI1 :
                            ctr_hi_sum[fbcm_pkg::WORD_W-1:0];

    assign ciph_out = (ciph_reg == fbcm_pkg::CIPH_ENC16) ? {n2_reg, n1_reg} : {n1_reg, n2_reg};

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        ciph_next  = ciph_reg;
        fin_next   = fin_reg;
        n1_next    = n1_reg;
        n2_next    = n2_reg;
        blk_next   = blk_reg;
        chain_next = chain_reg;
        mac_next   = mac_reg;
        src        = item.block_in;
        res        = blk_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    rnd_next   = '0;
                    blk_next   = item.block_in;
                    fin_next   = fbcm_pkg::FIN_IMM;
                    ciph_next  = fbcm_pkg::CIPH_ENC32;
                    state_next = ST_FIN;
                    unique case (item.kind)
                        fbcm_pkg::KIND_LOAD_SBOX:
                        begin
                            blk_next = '0;
                        end
                        fbcm_pkg::KIND_SET_IV:
                        begin
                            chain_next = item.block_in;
                        end
                        fbcm_pkg::KIND_SET_MAC:
                        begin
                            mac_next = item.block_in;
                        end
                        fbcm_pkg::KIND_INIT_CTR:
                        begin
                            src        = chain_reg;
                            fin_next   = fbcm_pkg::FIN_CHAIN;
                            state_next = ST_RUN;
                        end
                        fbcm_pkg::KIND_PROCESS:
                        begin
                            state_next = ST_RUN;
                            unique case (mode_reg)
                                fbcm_pkg::MODE_ECB_ENC:
                                begin
                                    fin_next = fbcm_pkg::FIN_PLAIN;
                                end
                                fbcm_pkg::MODE_ECB_DEC:
                                begin
                                    ciph_next = fbcm_pkg::CIPH_DEC32;
                                    fin_next  = fbcm_pkg::FIN_PLAIN;
                                end
                                fbcm_pkg::MODE_CTR:
                                begin
                                    src        = ctr_val;
                                    chain_next = ctr_val;
                                    fin_next   = fbcm_pkg::FIN_XOR;
                                end
                                fbcm_pkg::MODE_CFB_ENC:
                                begin
                                    src      = chain_reg;
                                    fin_next = fbcm_pkg::FIN_CFB_ENC;
                                end
                                fbcm_pkg::MODE_CFB_DEC:
                                begin
                                    src      = chain_reg;
                                    fin_next = fbcm_pkg::FIN_CFB_DEC;
                                end
                                fbcm_pkg::MODE_MAC:
                                begin
                                    src       = mac_reg ^ item.block_in;
                                    ciph_next = fbcm_pkg::CIPH_ENC16;
                                    fin_next  = fbcm_pkg::FIN_MAC;
                                end
                                fbcm_pkg::MODE_ENC16:
                                begin
                                    ciph_next = fbcm_pkg::CIPH_ENC16;
                                    fin_next  = fbcm_pkg::FIN_PLAIN;
                                end
                                fbcm_pkg::MODE_DEC16:
                                begin
                                    ciph_next = fbcm_pkg::CIPH_DEC16;
                                    fin_next  = fbcm_pkg::FIN_PLAIN;
                                end
                                default:
                                begin
                                    fin_next = fbcm_pkg::FIN_PLAIN;
                                end
                            endcase
                        end
                        default:
                        begin
                            blk_next = '0;
                        end
                    endcase
                    // 16-round decrypt starts with the halves exchanged
                    if (ciph_next == fbcm_pkg::CIPH_DEC16)
                    begin
                        n1_next = src[63:32];
                        n2_next = src[31:0];
                    end
                    else
                    begin
                        n1_next = src[31:0];
                        n2_next = src[63:32];
                    end
                end
            end
            ST_RUN:
            begin
                n1_next  = n2_reg ^ f_out;
                n2_next  = n1_reg;
                rnd_next = rnd_reg + 1'b1;
                if (last_rnd)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                case (fin_reg)
                    fbcm_pkg::FIN_IMM:     res = blk_reg;
                    fbcm_pkg::FIN_PLAIN:   res = ciph_out;
                    fbcm_pkg::FIN_XOR:     res = blk_reg ^ ciph_out;
                    fbcm_pkg::FIN_CFB_ENC: res = blk_reg ^ ciph_out;
                    fbcm_pkg::FIN_CFB_DEC: res = blk_reg ^ ciph_out;
                    fbcm_pkg::FIN_MAC:     res = ciph_out;
                    fbcm_pkg::FIN_CHAIN:   res = ciph_out;
                    default:               res = blk_reg;
                endcase
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                    case (fin_reg)
                        fbcm_pkg::FIN_CFB_ENC: chain_next = res;
                        fbcm_pkg::FIN_CFB_DEC: chain_next = blk_reg;
                        fbcm_pkg::FIN_CHAIN:   chain_next = res;
                        fbcm_pkg::FIN_MAC:     mac_next   = res;
                        default:               chain_next = chain_reg;
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            mode_reg      <= '0;
            sbox_reg      <= '0;
            chain_reg     <= '0;
            mac_reg       <= '0;
            rnd_reg       <= '0;
            ciph_reg      <= fbcm_pkg::CIPH_ENC32;
            fin_reg       <= fbcm_pkg::FIN_IMM;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            ciph_reg  <= ciph_next;
            fin_reg   <= fin_next;
            chain_reg <= chain_next;
            mac_reg   <= mac_next;
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (sbox_we)
            begin
                sbox_reg[item.row_index] <= item.block_in;
            end
            if (cfg_xfer)
            begin
                unique case (cfg.index)
                    fbcm_pkg::REG_KEY01: key_reg[0] <= cfg.data;
                    fbcm_pkg::REG_KEY23: key_reg[1] <= cfg.data;
                    fbcm_pkg::REG_KEY45: key_reg[2] <= cfg.data;
                    fbcm_pkg::REG_KEY67: key_reg[3] <= cfg.data;
                    fbcm_pkg::REG_MODE:  mode_reg   <= cfg.data[fbcm_pkg::MODE_W-1:0];
                    default:             mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        n1_reg  <= n1_next;
        n2_reg  <= n2_next;
        blk_reg <= blk_next;
        if (item_xfer)
        begin
            last_reg <= item.last_block;
        end
        if (fin_go)
        begin
            out_blk_reg  <= res;
            out_last_reg <= last_reg;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register lost its one-hot code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && (item.kind == fbcm_pkg::KIND_INIT_CTR ||
                       item.kind == fbcm_pkg::KIND_PROCESS))
        |=> (state_reg == ST_RUN && rnd_reg == '0))
        else $error("cipher work did not start at round zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && (ciph_reg == fbcm_pkg::CIPH_ENC16 ||
                                 ciph_reg == fbcm_pkg::CIPH_DEC16))
        |-> (rnd_reg[4] == 1'b0))
        else $error("16-round work ran past its last round");

    assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished item did not reach the result register");
`endif

endmodule
